/* src/fts_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package fts_pkg;

   // queues of one chip
   localparam int NQ = 7;
   localparam logic [2:0] Q_RD  = 3'd0;
   localparam logic [2:0] Q_WR  = 3'd1;
   localparam logic [2:0] Q_MRD = 3'd2;
   localparam logic [2:0] Q_MWR = 3'd3;
   localparam logic [2:0] Q_GRD = 3'd4;
   localparam logic [2:0] Q_GWR = 3'd5;
   localparam logic [2:0] Q_ERS = 3'd6;

   // request functions
   localparam logic [1:0] FN_ENQ   = 2'd0;
   localparam logic [1:0] FN_CHIP  = 2'd1;
   localparam logic [1:0] FN_FLUSH = 2'd2;
   localparam logic [1:0] FN_GUARD = 2'd3;

   // operation kinds
   localparam logic [1:0] KD_READ  = 2'd0;
   localparam logic [1:0] KD_WRITE = 2'd1;
   localparam logic [1:0] KD_ERASE = 2'd2;

   // response status
   localparam logic [2:0] ST_ACC  = 3'd0;
   localparam logic [2:0] ST_REJ  = 3'd1;
   localparam logic [2:0] ST_FULL = 3'd2;
   localparam logic [2:0] ST_DISP = 3'd3;
   localparam logic [2:0] ST_NONE = 3'd4;

   // stored entry: die, plane, page, tag
   localparam int ENTRY_W = 28;

   typedef enum logic [4:0] {
      OP_NOP,
      OP_LOAD,
      OP_ENQ,
      OP_CHIP_INIT,
      OP_SEL,
      OP_CLS_NEXT,
      OP_SCAN_RD,
      OP_IDX_INC,
      OP_FOUND,
      OP_TAKE_RD,
      OP_TAKE_SEC,
      OP_EMIT,
      OP_MOVE_RD,
      OP_CNT_DEC,
      OP_MOVE_WR,
      OP_CHIP_DONE,
      OP_CHIP_NEXT,
      OP_FINISH
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic req_enq;
      logic event_ok;
      logic sel_ok;
      logic last_cls;
      logic scan_more;
      logic die_idle;
      logic take_more;
      logic sec_ok;
      logic match;
      logic mv_more;
      logic chip_more;
   } stat_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  tag;
      logic [2:0]  chip;
      logic [1:0]  die;
      logic [1:0]  plane;
      logic [15:0] page;
      logic [1:0]  kind;
   } rsp_type;

endpackage

`default_nettype wire

/* src/flash_transaction_scheduler_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel  Ports                        Transfer
// request  start/busy, req_*            at edge with start high, busy low
// result   rsp_strobe, rsp_*            one cycle per strobe, no back-pressure
// config   csr_write_enable, csr_*      at edge with write enable high
//
// An enqueue latches the request, updates its queue, then gives a result.
// An event walks the chip's queues through one memory port, with a read and
// a check state per entry examined and a read and a write state per
// entry shifted in compaction; a flush tries chips until one dispatches.
// Synchronous reset clears counts, round-robin pointers and control; the
// entry memory is not cleared. The result side is never stalled.

module flash_transaction_scheduler_top #(
   parameter int CHANNELS    = 2,
   parameter int CHIPS       = 4,
   parameter int DIES        = 4,
   parameter int PLANES      = 4,
   parameter int QUEUE_DEPTH = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_func,
   input  wire logic [1:0]  req_channel,
   input  wire logic [2:0]  req_chip,
   input  wire logic [1:0]  req_die,
   input  wire logic [1:0]  req_plane,
   input  wire logic [15:0] req_page,
   input  wire logic [1:0]  req_txn_kind,
   input  wire logic [1:0]  req_source,
   input  wire logic [7:0]  req_tag,
   input  wire logic [15:0] req_die_busy_mask,
   input  wire logic        req_channel_busy,
   output logic             rsp_strobe,
   output logic [2:0]       rsp_status,
   output logic [7:0]       rsp_out_tag,
   output logic [2:0]       rsp_out_chip,
   output logic [1:0]       rsp_out_die,
   output logic [1:0]       rsp_out_plane,
   output logic [15:0]      rsp_out_page,
   output logic [1:0]       rsp_out_kind,
   output logic             rsp_last,
   input  wire logic        csr_write_enable,
   input  wire logic        csr_write_data
);

   fts_pkg::cmd_type  cmd;
   fts_pkg::stat_type st;
   fts_pkg::rsp_type  rsp_data;

   fts_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .st    (st),
      .cmd   (cmd),
      .busy  (busy)
   );

   fts_dpath #(
      .CHANNELS    (CHANNELS),
      .CHIPS       (CHIPS),
      .DIES        (DIES),
      .PLANES      (PLANES),
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .st                (st),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .req_func          (req_func),
      .req_channel       (req_channel),
      .req_chip          (req_chip),
      .req_die           (req_die),
      .req_plane         (req_plane),
      .req_page          (req_page),
      .req_txn_kind      (req_txn_kind),
      .req_source        (req_source),
      .req_tag           (req_tag),
      .req_die_busy_mask (req_die_busy_mask),
      .req_channel_busy  (req_channel_busy),
      .rsp_strobe        (rsp_strobe),
      .rsp_data          (rsp_data),
      .rsp_last          (rsp_last)
   );

   // unpack result fields
   assign rsp_status    = rsp_data.status;
   assign rsp_out_tag   = rsp_data.tag;
   assign rsp_out_chip  = rsp_data.chip;
   assign rsp_out_die   = rsp_data.die;
   assign rsp_out_plane = rsp_data.plane;
   assign rsp_out_page  = rsp_data.page;
   assign rsp_out_kind  = rsp_data.kind;

endmodule

`default_nettype wire

/* src/fts_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module fts_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire fts_pkg::stat_type st,
   output fts_pkg::cmd_type      cmd,
   output logic                  busy
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_ENQ  = 4'd1;
   localparam logic [3:0] S_EVT  = 4'd2;
   localparam logic [3:0] S_CLS  = 4'd3;
   localparam logic [3:0] S_SRD  = 4'd4;
   localparam logic [3:0] S_SCHK = 4'd5;
   localparam logic [3:0] S_TRD  = 4'd6;
   localparam logic [3:0] S_TCHK = 4'd7;
   localparam logic [3:0] S_MRD  = 4'd8;
   localparam logic [3:0] S_MWR  = 4'd9;
   localparam logic [3:0] S_CEND = 4'd10;
   localparam logic [3:0] S_FIN  = 4'd11;

   logic [3:0] state_ff, state_in;

   // sequencing of enqueue, queue selection, scan, take and compaction
   always_comb begin
      state_in = state_ff;
      cmd.op   = fts_pkg::OP_NOP;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.op   = fts_pkg::OP_LOAD;
               state_in = st.req_enq ? S_ENQ : S_EVT;
            end
         end
         S_ENQ: begin
            cmd.op   = fts_pkg::OP_ENQ;
            state_in = S_IDLE;
         end
         S_EVT: begin
            if (st.event_ok) begin
               cmd.op   = fts_pkg::OP_CHIP_INIT;
               state_in = S_CLS;
            end else begin
               state_in = S_FIN;
            end
         end
         S_CLS: begin
            if (st.sel_ok) begin
               cmd.op   = fts_pkg::OP_SEL;
               state_in = S_SRD;
            end else if (st.last_cls) begin
               state_in = S_CEND;
            end else begin
               cmd.op   = fts_pkg::OP_CLS_NEXT;
               state_in = S_CLS;
            end
         end
         S_SRD: begin
            if (st.scan_more) begin
               cmd.op   = fts_pkg::OP_SCAN_RD;
               state_in = S_SCHK;
            end else if (st.last_cls) begin
               state_in = S_CEND;
            end else begin
               cmd.op   = fts_pkg::OP_CLS_NEXT;
               state_in = S_CLS;
            end
         end
         S_SCHK: begin
            if (st.die_idle) begin
               cmd.op   = fts_pkg::OP_FOUND;
               state_in = S_TRD;
            end else begin
               cmd.op   = fts_pkg::OP_IDX_INC;
               state_in = S_SRD;
            end
         end
         S_TRD: begin
            if (st.take_more) begin
               cmd.op   = fts_pkg::OP_TAKE_RD;
               state_in = S_TCHK;
            end else if (st.sec_ok) begin
               cmd.op   = fts_pkg::OP_TAKE_SEC;
               state_in = S_TRD;
            end else begin
               cmd.op   = fts_pkg::OP_CHIP_DONE;
               state_in = S_FIN;
            end
         end
         S_TCHK: begin
            if (st.match) begin
               cmd.op   = fts_pkg::OP_EMIT;
               state_in = S_MRD;
            end else begin
               cmd.op   = fts_pkg::OP_IDX_INC;
               state_in = S_TRD;
            end
         end
         S_MRD: begin
            if (st.mv_more) begin
               cmd.op   = fts_pkg::OP_MOVE_RD;
               state_in = S_MWR;
            end else begin
               cmd.op   = fts_pkg::OP_CNT_DEC;
               state_in = S_TRD;
            end
         end
         S_MWR: begin
            cmd.op   = fts_pkg::OP_MOVE_WR;
            state_in = S_MRD;
         end
         S_CEND: begin
            cmd.op   = fts_pkg::OP_CHIP_NEXT;
            state_in = st.chip_more ? S_CLS : S_FIN;
         end
         S_FIN: begin
            cmd.op   = fts_pkg::OP_FINISH;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

`default_nettype wire

/* src/fts_dpath.sv */
`timescale 1ns / 1ps
`default_nettype none

module fts_dpath #(
   parameter int CHANNELS    = 2,
   parameter int CHIPS       = 4,
   parameter int DIES        = 4,
   parameter int PLANES      = 4,
   parameter int QUEUE_DEPTH = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire fts_pkg::cmd_type  cmd,
   output fts_pkg::stat_type      st,
   input  wire logic              csr_write_enable,
   input  wire logic              csr_write_data,
   input  wire logic [1:0]        req_func,
   input  wire logic [1:0]        req_channel,
   input  wire logic [2:0]        req_chip,
   input  wire logic [1:0]        req_die,
   input  wire logic [1:0]        req_plane,
   input  wire logic [15:0]       req_page,
   input  wire logic [1:0]        req_txn_kind,
   input  wire logic [1:0]        req_source,
   input  wire logic [7:0]        req_tag,
   input  wire logic [15:0]       req_die_busy_mask,
   input  wire logic              req_channel_busy,
   output logic                   rsp_strobe,
   output fts_pkg::rsp_type       rsp_data,
   output logic                   rsp_last
);

   localparam int ROWS   = CHANNELS * CHIPS;
   localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CHIP_W = (CHIPS > 1) ? $clog2(CHIPS) : 1;
   localparam int PL_W   = (PLANES > 1) ? $clog2(PLANES) : 1;
   localparam int SLOT_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int NB_W   = $clog2(PLANES + 1);
   localparam int TRY_W  = $clog2(CHIPS + 1);
   localparam int DEPTH  = ROWS * fts_pkg::NQ * QUEUE_DEPTH;
   localparam int ADDR_W = $clog2(DEPTH);

   typedef logic [fts_pkg::NQ-1:0][CNT_W-1:0] cnt_row_type;

   // configuration and latched request
   logic                mp_ff;
   logic [1:0]          func_ff, ch_ff, die_in_ff, plane_in_ff, kind_ff, src_ff;
   logic [2:0]          chip_ff;
   logic [15:0]         page_in_ff, mask_ff;
   logic [7:0]          tag_ff;
   logic                cbusy_ff;

   // scheduling state
   cnt_row_type         cnt_ff [ROWS];
   logic [CHIP_W-1:0]   rr_ff [CHANNELS];
   logic [CHIP_W-1:0]   cur_chip_ff;
   logic [TRY_W-1:0]    tries_ff;
   logic [1:0]          cls_ff;
   logic [2:0]          q_ff, qs_ff;
   logic                qs_vld_ff, second_ff;
   logic [CNT_W-1:0]    idx_ff, mv_ff;
   logic [1:0]          die_ff;
   logic [15:0]         page_ff;
   logic [PLANES-1:0]   bitmap_ff;
   logic [NB_W-1:0]     nb_ff;
   logic                pend_vld_ff;
   fts_pkg::rsp_type    pend_ff;
   fts_pkg::rsp_type    rsp_ff;
   logic                rsp_strobe_ff, rsp_last_ff;

   // queue memory
   logic [fts_pkg::ENTRY_W-1:0] mem [DEPTH];
   logic [fts_pkg::ENTRY_W-1:0] mem_q;

   logic [ROW_W-1:0]    row_cur;
   logic [CH_W-1:0]     ch_idx;
   cnt_row_type         cnt_row;
   logic [CNT_W-1:0]    cnt_q;
   logic [NB_W-1:0]     maxb;
   logic [CHIP_W-1:0]   chip_nxt;
   logic                flush;

   logic [2:0]          q_enq;
   logic                enq_bad, enq_full;
   logic [2:0]          enq_status;

   logic                sel_ok;
   logic [2:0]          sel_qp, sel_qs;
   logic                sel_qs_vld;

   logic [1:0]          e_die, e_plane;
   logic [15:0]         e_page;
   logic [7:0]          e_tag;
   int                  busy_bit;

   logic                rd_en, wr_en;
   logic [2:0]          rd_q, wr_q;
   logic [CNT_W-1:0]    rd_slot, wr_slot;
   logic [ADDR_W-1:0]   rd_addr, wr_addr;
   logic [fts_pkg::ENTRY_W-1:0] wr_data;
   logic [CNT_W:0]      mv_next;

   assign row_cur = ROW_W'(int'(ch_ff) * CHIPS + int'(cur_chip_ff));
   assign ch_idx  = ch_ff[CH_W-1:0];
   assign cnt_row = cnt_ff[row_cur];
   assign cnt_q   = cnt_row[q_ff];
   assign maxb    = mp_ff ? NB_W'(PLANES) : NB_W'(1);
   assign flush   = (func_ff != fts_pkg::FN_CHIP);
   assign chip_nxt = (int'(cur_chip_ff) == CHIPS - 1) ? '0 : cur_chip_ff + 1'b1;
   assign mv_next = {1'b0, mv_ff} + 1'b1;

   assign e_tag   = mem_q[7:0];
   assign e_page  = mem_q[23:8];
   assign e_plane = mem_q[25:24];
   assign e_die   = mem_q[27:26];
   assign busy_bit = int'(cur_chip_ff) * DIES + int'(e_die);

   // enqueue target queue and checks
   always_comb begin
      q_enq   = fts_pkg::Q_ERS;
      enq_bad = 1'b0;
      if (kind_ff == fts_pkg::KD_ERASE) begin
         q_enq = fts_pkg::Q_ERS;
      end else if (kind_ff != 2'd3 && src_ff != 2'd3) begin
         q_enq = {src_ff, kind_ff[0]};
      end else begin
         enq_bad = 1'b1;
      end
      if (int'(ch_ff) >= CHANNELS || int'(chip_ff) >= CHIPS ||
          int'(die_in_ff) >= DIES || int'(plane_in_ff) >= PLANES) begin
         enq_bad = 1'b1;
      end
      enq_full = (int'(cnt_row[q_enq]) >= QUEUE_DEPTH);
      enq_status = enq_bad ? fts_pkg::ST_REJ :
                   (enq_full ? fts_pkg::ST_FULL : fts_pkg::ST_ACC);
   end

   // primary and secondary queue of the current class
   always_comb begin
      sel_ok     = 1'b0;
      sel_qp     = fts_pkg::Q_ERS;
      sel_qs     = fts_pkg::Q_ERS;
      sel_qs_vld = 1'b0;
      unique case (cls_ff)
         fts_pkg::KD_READ: begin
            if (cnt_row[fts_pkg::Q_MRD] != '0) begin
               sel_ok = 1'b1;
               sel_qp = fts_pkg::Q_MRD;
               if (cnt_row[fts_pkg::Q_RD] != '0) begin
                  sel_qs = fts_pkg::Q_RD;
                  sel_qs_vld = 1'b1;
               end else if (cnt_row[fts_pkg::Q_GRD] != '0) begin
                  sel_qs = fts_pkg::Q_GRD;
                  sel_qs_vld = 1'b1;
               end
            end else if (cnt_row[fts_pkg::Q_RD] != '0) begin
               sel_ok = 1'b1;
               sel_qp = fts_pkg::Q_RD;
               sel_qs = fts_pkg::Q_GRD;
               sel_qs_vld = (cnt_row[fts_pkg::Q_GRD] != '0);
            end else if (cnt_row[fts_pkg::Q_WR] != '0) begin
               // gc reads held back behind user writes
               sel_ok = 1'b0;
            end else if (cnt_row[fts_pkg::Q_GRD] != '0) begin
               sel_ok = 1'b1;
               sel_qp = fts_pkg::Q_GRD;
            end
         end
         fts_pkg::KD_WRITE: begin
            if (cnt_row[fts_pkg::Q_MWR] != '0) begin
               sel_ok = 1'b1;
               sel_qp = fts_pkg::Q_MWR;
               if (cnt_row[fts_pkg::Q_WR] != '0) begin
                  sel_qs = fts_pkg::Q_WR;
                  sel_qs_vld = 1'b1;
               end else if (cnt_row[fts_pkg::Q_GWR] != '0) begin
                  sel_qs = fts_pkg::Q_GWR;
                  sel_qs_vld = 1'b1;
               end
            end else if (cnt_row[fts_pkg::Q_WR] != '0) begin
               sel_ok = 1'b1;
               sel_qp = fts_pkg::Q_WR;
               sel_qs = fts_pkg::Q_GWR;
               sel_qs_vld = (cnt_row[fts_pkg::Q_GWR] != '0);
            end else if (cnt_row[fts_pkg::Q_GWR] != '0) begin
               sel_ok = 1'b1;
               sel_qp = fts_pkg::Q_GWR;
            end
         end
         fts_pkg::KD_ERASE: begin
            sel_ok = (cnt_row[fts_pkg::Q_ERS] != '0);
            sel_qp = fts_pkg::Q_ERS;
         end
         default: begin
            sel_ok = 1'b0;
         end
      endcase
   end

   // status to the controller
   always_comb begin
      st.req_enq   = (req_func == fts_pkg::FN_ENQ);
      st.event_ok  = (int'(ch_ff) < CHANNELS) &&
                     ((func_ff == fts_pkg::FN_CHIP) ?
                      (int'(chip_ff) < CHIPS && !cbusy_ff) :
                      (func_ff == fts_pkg::FN_FLUSH || !cbusy_ff));
      st.sel_ok    = sel_ok;
      st.last_cls  = (cls_ff == fts_pkg::KD_ERASE);
      st.scan_more = (idx_ff < cnt_q);
      st.die_idle  = !(busy_bit < 16 && mask_ff[4'(busy_bit)]);
      st.take_more = (idx_ff < cnt_q) && (nb_ff < maxb);
      st.sec_ok    = !second_ff && qs_vld_ff && (nb_ff < maxb);
      st.match     = (e_die == die_ff) && !bitmap_ff[e_plane[PL_W-1:0]] &&
                     (bitmap_ff == '0 || e_page == page_ff);
      st.mv_more   = (mv_next < {1'b0, cnt_q});
      st.chip_more = flush && (int'(tries_ff) + 1 < CHIPS);
   end

   // memory port addressing
   always_comb begin
      rd_en   = 1'b0;
      rd_q    = q_ff;
      rd_slot = idx_ff;
      wr_en   = 1'b0;
      wr_q    = q_ff;
      wr_slot = mv_ff;
      wr_data = mem_q;
      priority case (cmd.op)
         fts_pkg::OP_SCAN_RD, fts_pkg::OP_TAKE_RD: begin
            rd_en = 1'b1;
         end
         fts_pkg::OP_MOVE_RD: begin
            rd_en   = 1'b1;
            rd_slot = mv_next[CNT_W-1:0];
         end
         fts_pkg::OP_MOVE_WR: begin
            wr_en = 1'b1;
         end
         fts_pkg::OP_ENQ: begin
            wr_en   = !enq_bad && !enq_full;
            wr_q    = q_enq;
            wr_slot = cnt_row[q_enq];
            wr_data = {die_in_ff, plane_in_ff, page_in_ff, tag_ff};
         end
         default: begin
            rd_en = 1'b0;
         end
      endcase
      rd_addr = ADDR_W'((int'(row_cur) * fts_pkg::NQ + int'(rd_q)) * QUEUE_DEPTH +
                        int'(rd_slot[SLOT_W-1:0]));
      wr_addr = ADDR_W'((int'(row_cur) * fts_pkg::NQ + int'(wr_q)) * QUEUE_DEPTH +
                        int'(wr_slot[SLOT_W-1:0]));
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         mem_q <= mem[rd_addr];
      end
   end

   // control state: counts, pointers, pending result, strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         mp_ff         <= 1'b0;
         pend_vld_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         for (int r = 0; r < ROWS; r++) begin
            cnt_ff[r] <= '0;
         end
         for (int c = 0; c < CHANNELS; c++) begin
            rr_ff[c] <= '0;
         end
      end else begin
         rsp_strobe_ff <= 1'b0;
         if (csr_write_enable) begin
            mp_ff <= csr_write_data;
         end
         unique case (cmd.op)
            fts_pkg::OP_ENQ: begin
               rsp_strobe_ff <= 1'b1;
               if (!enq_bad && !enq_full) begin
                  cnt_ff[row_cur][q_enq] <= cnt_row[q_enq] + 1'b1;
               end
            end
            fts_pkg::OP_EMIT: begin
               pend_vld_ff   <= 1'b1;
               rsp_strobe_ff <= pend_vld_ff;
            end
            fts_pkg::OP_CNT_DEC: begin
               cnt_ff[row_cur][q_ff] <= cnt_q - 1'b1;
            end
            fts_pkg::OP_CHIP_DONE, fts_pkg::OP_CHIP_NEXT: begin
               if (flush) begin
                  rr_ff[ch_idx] <= chip_nxt;
               end
            end
            fts_pkg::OP_FINISH: begin
               pend_vld_ff   <= 1'b0;
               rsp_strobe_ff <= 1'b1;
            end
            default: begin
               pend_vld_ff <= pend_vld_ff;
            end
         endcase
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      unique case (cmd.op)
         fts_pkg::OP_LOAD: begin
            func_ff     <= req_func;
            ch_ff       <= req_channel;
            chip_ff     <= req_chip;
            cur_chip_ff <= req_chip[CHIP_W-1:0];
            die_in_ff   <= req_die;
            plane_in_ff <= req_plane;
            page_in_ff  <= req_page;
            kind_ff     <= req_txn_kind;
            src_ff      <= req_source;
            tag_ff      <= req_tag;
            mask_ff     <= req_die_busy_mask;
            cbusy_ff    <= req_channel_busy;
         end
         fts_pkg::OP_ENQ: begin
            rsp_ff      <= fts_pkg::rsp_type'({enq_status, tag_ff, 25'd0});
            rsp_last_ff <= 1'b1;
         end
         fts_pkg::OP_CHIP_INIT: begin
            cur_chip_ff <= (func_ff == fts_pkg::FN_CHIP) ? chip_ff[CHIP_W-1:0] : rr_ff[ch_idx];
            tries_ff    <= '0;
            cls_ff      <= fts_pkg::KD_READ;
         end
         fts_pkg::OP_SEL: begin
            q_ff      <= sel_qp;
            qs_ff     <= sel_qs;
            qs_vld_ff <= sel_qs_vld;
            second_ff <= 1'b0;
            idx_ff    <= '0;
            nb_ff     <= '0;
            bitmap_ff <= '0;
         end
         fts_pkg::OP_CLS_NEXT: begin
            cls_ff <= cls_ff + 1'b1;
         end
         fts_pkg::OP_IDX_INC: begin
            idx_ff <= idx_ff + 1'b1;
         end
         fts_pkg::OP_FOUND: begin
            die_ff  <= e_die;
            page_ff <= e_page;
            idx_ff  <= '0;
         end
         fts_pkg::OP_TAKE_SEC: begin
            q_ff      <= qs_ff;
            second_ff <= 1'b1;
            idx_ff    <= '0;
         end
         fts_pkg::OP_EMIT: begin
            bitmap_ff[e_plane[PL_W-1:0]] <= 1'b1;
            nb_ff       <= nb_ff + 1'b1;
            mv_ff       <= idx_ff;
            pend_ff     <= fts_pkg::rsp_type'({fts_pkg::ST_DISP, e_tag, 3'(cur_chip_ff),
                                               e_die, e_plane, e_page, cls_ff});
            rsp_ff      <= pend_ff;
            rsp_last_ff <= 1'b0;
         end
         fts_pkg::OP_MOVE_WR: begin
            mv_ff <= mv_next[CNT_W-1:0];
         end
         fts_pkg::OP_CHIP_NEXT: begin
            cur_chip_ff <= chip_nxt;
            tries_ff    <= tries_ff + 1'b1;
            cls_ff      <= fts_pkg::KD_READ;
         end
         fts_pkg::OP_FINISH: begin
            rsp_last_ff <= 1'b1;
            if (pend_vld_ff) begin
               rsp_ff <= pend_ff;
            end else begin
               rsp_ff <= fts_pkg::rsp_type'({fts_pkg::ST_NONE, 33'd0});
            end
         end
         default: begin
            idx_ff <= idx_ff;
         end
      endcase
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

`default_nettype wire

/* test/fts_checker.sv */
`timescale 1ns / 1ps

// Watches the request, result and register ports of the scheduler, predicts
// every result and compares each result against the oldest expectation.
module fts_checker #(
   parameter int CHANNELS    = 2,
   parameter int CHIPS       = 4,
   parameter int DIES        = 4,
   parameter int PLANES      = 4,
   parameter int QUEUE_DEPTH = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic        busy,
   input  wire logic [1:0]  req_func,
   input  wire logic [1:0]  req_channel,
   input  wire logic [2:0]  req_chip,
   input  wire logic [1:0]  req_die,
   input  wire logic [1:0]  req_plane,
   input  wire logic [15:0] req_page,
   input  wire logic [1:0]  req_txn_kind,
   input  wire logic [1:0]  req_source,
   input  wire logic [7:0]  req_tag,
   input  wire logic [15:0] req_die_busy_mask,
   input  wire logic        req_channel_busy,
   input  wire logic        rsp_strobe,
   input  wire logic [2:0]  rsp_status,
   input  wire logic [7:0]  rsp_out_tag,
   input  wire logic [2:0]  rsp_out_chip,
   input  wire logic [1:0]  rsp_out_die,
   input  wire logic [1:0]  rsp_out_plane,
   input  wire logic [15:0] rsp_out_page,
   input  wire logic [1:0]  rsp_out_kind,
   input  wire logic        rsp_last,
   input  wire logic        csr_write_enable,
   input  wire logic        csr_write_data,
   output int               fail_count,
   output int               pending
);

   typedef struct packed {
      fts_pkg::rsp_type r;
      logic             last;
   } sched_rsp_type;

   // predicted scheduler state
   logic [fts_pkg::ENTRY_W-1:0] q_entry [CHANNELS][CHIPS][fts_pkg::NQ][QUEUE_DEPTH];
   int                 q_count [CHANNELS][CHIPS][fts_pkg::NQ];
   int                 rr_ptr  [CHANNELS];
   logic               multiplane;

   fts_pkg::rsp_type batch_q[$];
   logic [3:0]       planes_used;
   sched_rsp_type    sched_rsp_q[$];

   assign pending = sched_rsp_q.size();

   function automatic bit die_is_busy(int cp, logic [1:0] die, logic [15:0] mask);
      int idx;
      idx = cp * DIES + die;
      if (idx >= 16) return 0;
      return mask[idx];
   endfunction

   // move matching entries of one queue into the batch
   function automatic void take_queue(int ch, int cp, int q, logic [1:0] die,
                                      logic [15:0] page, int maxb, logic [1:0] kind);
      int i;
      logic [fts_pkg::ENTRY_W-1:0] e;
      fts_pkg::rsp_type r;
      i = 0;
      while (i < q_count[ch][cp][q] && batch_q.size() < maxb) begin
         e = q_entry[ch][cp][q][i];
         if (e[27:26] == die && !planes_used[e[25:24]] &&
             (planes_used == 4'd0 || e[23:8] == page)) begin
            planes_used[e[25:24]] = 1'b1;
            r = '0;
            r.status = fts_pkg::ST_DISP;
            r.tag    = e[7:0];
            r.chip   = cp[2:0];
            r.die    = e[27:26];
            r.plane  = e[25:24];
            r.page   = e[23:8];
            r.kind   = kind;
            batch_q.push_back(r);
            for (int j = i; j < q_count[ch][cp][q] - 1; j++)
               q_entry[ch][cp][q][j] = q_entry[ch][cp][q][j+1];
            q_count[ch][cp][q]--;
         end else begin
            i++;
         end
      end
   endfunction

   function automatic void build_batch(int ch, int cp, int qp, int qs,
                                       logic [1:0] kind, logic [15:0] mask);
      logic [fts_pkg::ENTRY_W-1:0] e;
      bit found;
      int maxb;
      logic [1:0] die;
      logic [15:0] page;
      found = 0;
      die = '0;
      page = '0;
      maxb = multiplane ? PLANES : 1;
      for (int i = 0; i < q_count[ch][cp][qp] && !found; i++) begin
         e = q_entry[ch][cp][qp][i];
         if (!die_is_busy(cp, e[27:26], mask)) begin
            die = e[27:26];
            page = e[23:8];
            found = 1;
         end
      end
      if (!found) return;
      planes_used = 4'd0;
      take_queue(ch, cp, qp, die, page, maxb, kind);
      if (qs >= 0 && batch_q.size() < maxb)
         take_queue(ch, cp, qs, die, page, maxb, kind);
   endfunction

   // one chip: reads, then writes, then erases; mapping first
   function automatic void dispatch_chip(int ch, int cp, logic [15:0] mask);
      int qp, qs;
      bit reads;
      batch_q.delete();
      qp = -1;
      qs = -1;
      reads = 1;
      if (q_count[ch][cp][fts_pkg::Q_MRD] != 0) begin
         qp = int'(fts_pkg::Q_MRD);
         if (q_count[ch][cp][fts_pkg::Q_RD] != 0) qs = int'(fts_pkg::Q_RD);
         else if (q_count[ch][cp][fts_pkg::Q_GRD] != 0) qs = int'(fts_pkg::Q_GRD);
      end else if (q_count[ch][cp][fts_pkg::Q_RD] != 0) begin
         qp = int'(fts_pkg::Q_RD);
         if (q_count[ch][cp][fts_pkg::Q_GRD] != 0) qs = int'(fts_pkg::Q_GRD);
      end else if (q_count[ch][cp][fts_pkg::Q_WR] != 0) begin
         // GC reads held back behind pending user writes
         reads = 0;
      end else if (q_count[ch][cp][fts_pkg::Q_GRD] != 0) begin
         qp = int'(fts_pkg::Q_GRD);
      end
      if (reads && qp >= 0) build_batch(ch, cp, qp, qs, fts_pkg::KD_READ, mask);
      if (batch_q.size() != 0) return;

      qp = -1;
      qs = -1;
      if (q_count[ch][cp][fts_pkg::Q_MWR] != 0) begin
         qp = int'(fts_pkg::Q_MWR);
         if (q_count[ch][cp][fts_pkg::Q_WR] != 0) qs = int'(fts_pkg::Q_WR);
         else if (q_count[ch][cp][fts_pkg::Q_GWR] != 0) qs = int'(fts_pkg::Q_GWR);
      end else if (q_count[ch][cp][fts_pkg::Q_WR] != 0) begin
         qp = int'(fts_pkg::Q_WR);
         if (q_count[ch][cp][fts_pkg::Q_GWR] != 0) qs = int'(fts_pkg::Q_GWR);
      end else if (q_count[ch][cp][fts_pkg::Q_GWR] != 0) begin
         qp = int'(fts_pkg::Q_GWR);
      end
      if (qp >= 0) build_batch(ch, cp, qp, qs, fts_pkg::KD_WRITE, mask);
      if (batch_q.size() != 0) return;

      if (q_count[ch][cp][fts_pkg::Q_ERS] != 0)
         build_batch(ch, cp, int'(fts_pkg::Q_ERS), -1, fts_pkg::KD_ERASE, mask);
   endfunction

   function automatic void predict_request();
      int q, ch, cp;
      fts_pkg::rsp_type r;
      sched_rsp_type x;
      ch = req_channel;
      r = '0;
      batch_q.delete();
      if (req_func == fts_pkg::FN_ENQ) begin
         q = -1;
         if (req_txn_kind == fts_pkg::KD_ERASE) q = int'(fts_pkg::Q_ERS);
         else if (req_txn_kind < 2 && req_source < 3) q = req_txn_kind + 2 * req_source;
         r.tag = req_tag;
         if (ch >= CHANNELS || req_chip >= CHIPS || req_die >= DIES ||
             req_plane >= PLANES || q < 0) begin
            r.status = fts_pkg::ST_REJ;
         end else if (q_count[ch][req_chip][q] >= QUEUE_DEPTH) begin
            r.status = fts_pkg::ST_FULL;
         end else begin
            q_entry[ch][req_chip][q][q_count[ch][req_chip][q]] =
               {req_die, req_plane, req_page, req_tag};
            q_count[ch][req_chip][q]++;
            r.status = fts_pkg::ST_ACC;
         end
         batch_q.push_back(r);
      end else if (ch < CHANNELS) begin
         if (req_func == fts_pkg::FN_CHIP) begin
            if (req_chip < CHIPS && !req_channel_busy)
               dispatch_chip(ch, req_chip, req_die_busy_mask);
         end else if (req_func == fts_pkg::FN_FLUSH || !req_channel_busy) begin
            // round-robin over chips, stop at the first that dispatches
            for (int i = 0; i < CHIPS; i++) begin
               cp = rr_ptr[ch] % CHIPS;
               dispatch_chip(ch, cp, req_die_busy_mask);
               rr_ptr[ch] = (cp + 1) % CHIPS;
               if (batch_q.size() != 0) break;
            end
         end
      end
      if (batch_q.size() == 0) begin
         r = '0;
         r.status = fts_pkg::ST_NONE;
         batch_q.push_back(r);
      end
      foreach (batch_q[i]) begin
         x.r = batch_q[i];
         x.last = (i == batch_q.size() - 1);
         sched_rsp_q.push_back(x);
      end
   endfunction

   function automatic void check_field(string name, int exp_v, int act_v);
      if (exp_v != act_v) begin
         $display("%0t: result %s mismatch: expected %0h, actual %0h",
                  $time, name, exp_v, act_v);
         fail_count++;
      end
   endfunction

   initial fail_count = 0;

   always @(posedge clock) begin
      if (reset) begin
         foreach (q_count[a, b, c]) q_count[a][b][c] = 0;
         foreach (rr_ptr[a]) rr_ptr[a] = 0;
         multiplane = 1'b0;
         sched_rsp_q.delete();
      end else begin
         if (csr_write_enable) multiplane = csr_write_data;
         if (start && !busy) predict_request();
         if (rsp_strobe) begin
            if (sched_rsp_q.size() == 0) begin
               $display("%0t: unexpected result transfer, status %0d tag %0h",
                        $time, rsp_status, rsp_out_tag);
               fail_count++;
            end else begin
               sched_rsp_type x;
               x = sched_rsp_q.pop_front();
               check_field("status", x.r.status, rsp_status);
               check_field("tag",    x.r.tag,    rsp_out_tag);
               check_field("chip",   x.r.chip,   rsp_out_chip);
               check_field("die",    x.r.die,    rsp_out_die);
               check_field("plane",  x.r.plane,  rsp_out_plane);
               check_field("page",   x.r.page,   rsp_out_page);
               check_field("kind",   x.r.kind,   rsp_out_kind);
               check_field("last",   x.last,     rsp_last);
            end
         end
      end
   end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

   typedef struct packed {
      logic [1:0]  func;
      logic [1:0]  channel;
      logic [2:0]  chip;
      logic [1:0]  die;
      logic [1:0]  plane;
      logic [15:0] page;
      logic [1:0]  kind;
      logic [1:0]  source;
      logic [7:0]  tag;
      logic [15:0] mask;
      logic        chan_busy;
   } sched_req_type;

   localparam int QUEUE_DEPTH_FILL = 9;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          start = 1'b0;
   logic          busy;
   sched_req_type req = '0;
   logic          csr_write_enable = 1'b0;
   logic          csr_write_data = 1'b0;
   logic          rsp_strobe;
   logic [2:0]    rsp_status;
   logic [7:0]    rsp_out_tag;
   logic [2:0]    rsp_out_chip;
   logic [1:0]    rsp_out_die;
   logic [1:0]    rsp_out_plane;
   logic [15:0]   rsp_out_page;
   logic [1:0]    rsp_out_kind;
   logic          rsp_last;
   int            fail_count;
   int            pending;

   int            idle_pct;
   int            focus_chip;
   logic [15:0]   page_base;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   flash_transaction_scheduler_top DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_func(req.func), .req_channel(req.channel), .req_chip(req.chip),
      .req_die(req.die), .req_plane(req.plane), .req_page(req.page),
      .req_txn_kind(req.kind), .req_source(req.source), .req_tag(req.tag),
      .req_die_busy_mask(req.mask), .req_channel_busy(req.chan_busy),
      .rsp_strobe(rsp_strobe), .rsp_status(rsp_status), .rsp_out_tag(rsp_out_tag),
      .rsp_out_chip(rsp_out_chip), .rsp_out_die(rsp_out_die),
      .rsp_out_plane(rsp_out_plane), .rsp_out_page(rsp_out_page),
      .rsp_out_kind(rsp_out_kind), .rsp_last(rsp_last),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   fts_checker u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_func(req.func), .req_channel(req.channel), .req_chip(req.chip),
      .req_die(req.die), .req_plane(req.plane), .req_page(req.page),
      .req_txn_kind(req.kind), .req_source(req.source), .req_tag(req.tag),
      .req_die_busy_mask(req.mask), .req_channel_busy(req.chan_busy),
      .rsp_strobe(rsp_strobe), .rsp_status(rsp_status), .rsp_out_tag(rsp_out_tag),
      .rsp_out_chip(rsp_out_chip), .rsp_out_die(rsp_out_die),
      .rsp_out_plane(rsp_out_plane), .rsp_out_page(rsp_out_page),
      .rsp_out_kind(rsp_out_kind), .rsp_last(rsp_last),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .fail_count(fail_count), .pending(pending)
   );

   // idle cycle by cycle at the set rate, then present one request and
   // hold it until the transfer
   task automatic send_req(input sched_req_type r);
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      req   <= r;
      start <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   // drop start and wait until the block has drained every result
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic write_multiplane(input logic value);
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic sched_req_type enq(int ch, int cp, int die, int pl, int page,
                                         int kind, int src, int tag);
      sched_req_type r;
      r = '0;
      r.func = fts_pkg::FN_ENQ;
      r.channel = 2'(ch);
      r.chip = 3'(cp);
      r.die = 2'(die);
      r.plane = 2'(pl);
      r.page = 16'(page);
      r.kind = 2'(kind);
      r.source = 2'(src);
      r.tag = 8'(tag);
      return r;
   endfunction

   function automatic sched_req_type evt(logic [1:0] fn, int ch, int cp, int mask, int cbusy);
      sched_req_type r;
      r = '0;
      r.func = fn;
      r.channel = 2'(ch);
      r.chip = 3'(cp);
      r.mask = 16'(mask);
      r.chan_busy = (cbusy != 0);
      return r;
   endfunction

   function automatic sched_req_type rand_req();
      sched_req_type r;
      int roll;
      roll = $urandom_range(0, 99);
      r = '0;
      r.mask = 16'($urandom);
      r.chan_busy = 1'($urandom_range(0, 1));
      if (roll < 10) begin
         // noise over the full field ranges
         r = sched_req_type'(56'({$urandom, $urandom}));
      end else if (roll < 68) begin
         // mostly well-formed enqueue onto a focused chip, few pages
         r.func = fts_pkg::FN_ENQ;
         r.channel = 2'($urandom_range(0, 1));
         r.chip = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 3)) : 3'(focus_chip);
         r.die = 2'($urandom_range(0, 3));
         r.plane = 2'($urandom_range(0, 3));
         r.page = ($urandom_range(0, 3) == 0) ? 16'($urandom) :
                  16'(page_base + $urandom_range(0, 1));
         r.kind = 2'($urandom_range(0, 2));
         r.source = 2'($urandom_range(0, 2));
         r.tag = 8'($urandom);
      end else begin
         r.func = 2'($urandom_range(1, 3));
         r.channel = ($urandom_range(0, 19) == 0) ? 2'($urandom_range(2, 3)) :
                     2'($urandom_range(0, 1));
         r.chip = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(4, 7)) : 3'(focus_chip);
         r.mask = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'($urandom & $urandom & $urandom);
         r.chan_busy = ($urandom_range(0, 4) == 0);
      end
      return r;
   endfunction

   initial begin
      idle_pct = 0;
      focus_chip = 0;
      page_base = 16'h1234;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, rejects, busy cases, GC read holdback, full queue
      send_req(enq(0, 0, 0, 0, 16'h0000, fts_pkg::KD_READ, 0, 8'h00));
      send_req(enq(0, 3, 3, 3, 16'hFFFF, fts_pkg::KD_WRITE, 1, 8'hFF));
      send_req(enq(2, 0, 0, 0, 16'h0001, fts_pkg::KD_READ, 0, 8'h11));
      send_req(enq(1, 7, 0, 0, 16'h0002, fts_pkg::KD_READ, 0, 8'h22));
      send_req(enq(0, 0, 1, 1, 16'h0003, 3, 0, 8'h33));
      send_req(enq(0, 0, 1, 1, 16'h0004, fts_pkg::KD_READ, 3, 8'h44));
      send_req(enq(1, 2, 2, 2, 16'hA5A5, fts_pkg::KD_ERASE, 3, 8'h55));
      send_req(evt(fts_pkg::FN_CHIP, 0, 0, 0, 1));
      send_req(evt(fts_pkg::FN_CHIP, 0, 5, 0, 0));
      send_req(evt(fts_pkg::FN_FLUSH, 3, 0, 0, 0));
      send_req(evt(fts_pkg::FN_CHIP, 0, 0, 16'hFFFF, 0));
      send_req(evt(fts_pkg::FN_CHIP, 0, 0, 0, 0));
      send_req(enq(0, 1, 2, 0, 16'h0100, fts_pkg::KD_READ, 2, 8'h66));
      send_req(enq(0, 1, 2, 1, 16'h0200, fts_pkg::KD_WRITE, 0, 8'h77));
      send_req(evt(fts_pkg::FN_CHIP, 0, 1, 0, 0));
      send_req(evt(fts_pkg::FN_GUARD, 0, 0, 0, 1));
      send_req(evt(fts_pkg::FN_FLUSH, 0, 0, 16'h5555, 1));
      for (int i = 0; i < QUEUE_DEPTH_FILL; i++)
         send_req(enq(0, 2, 1, i % 4, 16'h0005, fts_pkg::KD_READ, 0, 8'h80 + i));
      send_req(evt(fts_pkg::FN_GUARD, 1, 0, 0, 0));

      // random phases: no idling, sender idle, receiver phase (cannot stall),
      // sender idle at a low rate; multiplane alternates
      for (int ph = 0; ph < 4; ph++) begin
         write_multiplane(ph % 2 == 0);
         idle_pct = (ph == 1) ? 67 : (ph == 3) ? 10 : 0;
         for (int n = 0; n < 22; n++) begin
            if (n % 12 == 0) begin
               focus_chip = $urandom_range(0, 3);
               page_base = 16'($urandom);
            end
            // hold off until the block has answered everything
            if (ph == 2 && n == 15) drain();
            send_req(rand_req());
         end
      end
      write_multiplane(1'b0);
      for (int n = 0; n < 12; n++)
         send_req(evt(fts_pkg::FN_FLUSH, n % 2, 0, 0, 0));

      drain();
      repeat (50) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("** flash_transaction_scheduler_top: PASSED **");
      end else begin
         $display("** flash_transaction_scheduler_top: FAILED **");
      end
      $finish;
   end

   // run limit
   initial begin
      #20ms;
      $display("** flash_transaction_scheduler_top: FAILED **");
      $finish;
   end

endmodule

/* flash_transaction_scheduler_top.f */
src/fts_pkg.sv
src/fts_ctrl.sv
src/fts_dpath.sv
src/flash_transaction_scheduler_top.sv
test/fts_checker.sv
test/tb_top.sv
